### hdl/spa_pkg.sv
package spa_pkg;

   // defaults for the top-level parameters
   localparam int DEF_COLORS    = 3;
   localparam int DEF_FRAC_BITS = 30;

   // fixed field widths
   localparam int SLOTS   = 4;
   localparam int SLOT_W  = 2;
   localparam int INDEX_W = 4;
   localparam int ELEM_W  = 32;
   localparam int FACE_W  = 33;
   localparam int TOTAL_W = 64;
   localparam int COUNT_W = 32;

   // one queued face job
   typedef struct packed {
      logic temporal;
      logic last;
   } job_type;

endpackage

### hdl/spa_req_if.sv
interface spa_req_if;
   import spa_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [SLOT_W-1:0]        matrix_slot;
   logic [INDEX_W-1:0]       element_index;
   logic signed [ELEM_W-1:0] elem_re;
   logic signed [ELEM_W-1:0] elem_im;
   logic                     plane_temporal;
   logic                     batch_end;

   modport source (output valid, matrix_slot, element_index, elem_re, elem_im,
                   plane_temporal, batch_end, input ready);
   modport sink (input valid, matrix_slot, element_index, elem_re, elem_im,
                 plane_temporal, batch_end, output ready);
endinterface

### hdl/spa_rsp_if.sv
interface spa_rsp_if;
   import spa_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [FACE_W-1:0]  face_value;
   logic signed [TOTAL_W-1:0] spatial_total;
   logic signed [TOTAL_W-1:0] temporal_total;
   logic [COUNT_W-1:0]        faces_seen;
   logic                      sweep_done;
   logic                      overflowed;

   modport source (output valid, face_value, spatial_total, temporal_total, faces_seen,
                   sweep_done, overflowed, input ready);
   modport sink (input valid, face_value, spatial_total, temporal_total, faces_seen,
                 sweep_done, overflowed, output ready);
endinterface

### hdl/spa_ram.sv
module spa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 36
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hdl/spa_front.sv
module spa_front #(
   parameter int COLORS = spa_pkg::DEF_COLORS
) (
   spa_req_if.sink                                          req,
   input  logic                                             back_idle,
   input  logic                                             queue_empty,
   output logic                                             wr_en,
   output logic [$clog2(spa_pkg::SLOTS*COLORS*COLORS)-1:0]  wr_addr,
   output logic [2*spa_pkg::ELEM_W-1:0]                     wr_data,
   output logic                                             push,
   output spa_pkg::job_type                                 job
);
   import spa_pkg::*;

   localparam int NSQ = COLORS * COLORS;
   localparam int AW  = $clog2(SLOTS * NSQ);

   logic accept;
   logic in_range;

   // store writes may not overlap a face computation
   assign req.ready = queue_empty & back_idle;
   assign accept    = req.valid & req.ready;
   // one extra bit so that a full index field still compares correctly
   assign in_range  = {1'b0, req.element_index} < (INDEX_W+1)'(NSQ);

   // link store write
   assign wr_en   = accept & in_range;
   assign wr_addr = AW'(req.matrix_slot) * AW'(NSQ) + AW'(req.element_index);
   assign wr_data = {req.elem_re, req.elem_im};

   // final element of D raises a face job
   assign push = wr_en & (req.matrix_slot == SLOT_W'(SLOTS - 1))
                 & (req.element_index == INDEX_W'(NSQ - 1));
   assign job.temporal = req.plane_temporal;
   assign job.last     = req.batch_end;
endmodule

### hdl/spa_queue.sv
module spa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  spa_pkg::job_type push_job,
   input  logic             pop,
   output logic             empty,
   output spa_pkg::job_type head
);
   import spa_pkg::*;

   job_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign empty   = (count_ff == 2'd0);
   assign head    = q_ff[rd_ptr_ff];
   assign do_push = push & (count_ff != 2'd2);
   assign do_pop  = pop & ~empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_job;
      end
   end
endmodule

### hdl/spa_back.sv
module spa_back #(
   parameter int COLORS    = spa_pkg::DEF_COLORS,
   parameter int FRAC_BITS = spa_pkg::DEF_FRAC_BITS
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            queue_empty,
   input  spa_pkg::job_type                                head,
   output logic                                            pop,
   output logic                                            idle,
   output logic [$clog2(spa_pkg::SLOTS*COLORS*COLORS)-1:0] rd_addr,
   input  logic [2*spa_pkg::ELEM_W-1:0]                    rd_data,
   spa_rsp_if.source                                       rsp
);
   import spa_pkg::*;

   localparam int NSQ    = COLORS * COLORS;
   localparam int AW     = $clog2(SLOTS * NSQ);
   localparam int CW     = $clog2(COLORS);
   localparam int MW     = $clog2(NSQ);
   localparam int PROD_W = 2 * ELEM_W;
   localparam int RND_W  = PROD_W - FRAC_BITS;
   localparam int ACC_W  = RND_W + 6;

   typedef enum logic [3:0] {
      S_IDLE, S_RDX, S_RDY, S_LATY, S_M0, S_M1, S_M2, S_M3, S_NEXT, S_STORE, S_OUT
   } state_type;

   typedef enum logic [1:0] {P_AB, P_TC, P_FACE} phase_type;

   state_type                 state_ff;
   phase_type                 phase_ff;
   job_type                   job_ff;
   logic [CW-1:0]             row_ff, col_ff, k_ff;
   logic signed [ELEM_W-1:0]  x_re_ff, x_im_ff, y_re_ff, y_im_ff;
   logic [2*ELEM_W-1:0]       t_ff [NSQ];
   logic [2*ELEM_W-1:0]       u_ff [NSQ];
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic                      pv_ff;
   logic [1:0]                psel_ff;
   logic signed [ACC_W-1:0]   sr_ff, si_ff;

   logic signed [TOTAL_W-1:0] spatial_ff, temporal_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic                      sat_ff;

   logic                      rsp_valid_ff;
   logic signed [FACE_W-1:0]  rsp_face_ff;
   logic signed [TOTAL_W-1:0] rsp_spatial_ff, rsp_temporal_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_done_ff, rsp_ovf_ff;

   logic [MW-1:0]             ik, kj, jk, rc;
   logic [AW-1:0]             x_addr, y_addr;
   logic signed [ELEM_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0]  rnd_full;
   logic signed [ACC_W-1:0]   rnd;
   logic signed [ACC_W-1:0]   sr_clamp, si_clamp;
   logic signed [FACE_W-1:0]  face;
   logic signed [TOTAL_W:0]   sum_ext;
   logic signed [TOTAL_W-1:0] sum_sat;
   logic                      sum_ovf;
   logic                      slot_free;

   // element positions within a matrix
   always_comb begin
      ik = MW'(row_ff) * MW'(COLORS) + MW'(k_ff);
      kj = MW'(k_ff) * MW'(COLORS) + MW'(col_ff);
      jk = MW'(col_ff) * MW'(COLORS) + MW'(k_ff);
      rc = MW'(row_ff) * MW'(COLORS) + MW'(col_ff);
   end

   // link store addresses of both operands
   always_comb begin
      x_addr = AW'(ik);
      case (phase_ff)
         P_AB:    y_addr = AW'(NSQ) + AW'(kj);
         P_TC:    y_addr = AW'(2 * NSQ) + AW'(jk);
         P_FACE:  y_addr = AW'(3 * NSQ) + AW'(rc);
         default: y_addr = AW'(rc);
      endcase
      rd_addr = (state_ff == S_RDX && phase_ff == P_AB) ? x_addr : y_addr;
   end

   // shared multiplier operand selection
   always_comb begin
      case (state_ff)
         S_M0:    begin mul_a = x_re_ff; mul_b = y_re_ff; end
         S_M1:    begin mul_a = x_im_ff; mul_b = y_im_ff; end
         S_M2:    begin mul_a = x_im_ff; mul_b = y_re_ff; end
         default: begin mul_a = x_re_ff; mul_b = y_im_ff; end
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // round half up, then clamps
   always_comb begin
      rnd_full = (prod_ff + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      rnd      = ACC_W'(signed'(rnd_full[RND_W-1:0]));
      if (sr_ff > ACC_W'(signed'(32'sh7fffffff))) begin
         sr_clamp = ACC_W'(signed'(32'sh7fffffff));
      end else if (sr_ff < ACC_W'(signed'(32'sh80000000))) begin
         sr_clamp = ACC_W'(signed'(32'sh80000000));
      end else begin
         sr_clamp = sr_ff;
      end
      if (si_ff > ACC_W'(signed'(32'sh7fffffff))) begin
         si_clamp = ACC_W'(signed'(32'sh7fffffff));
      end else if (si_ff < ACC_W'(signed'(32'sh80000000))) begin
         si_clamp = ACC_W'(signed'(32'sh80000000));
      end else begin
         si_clamp = si_ff;
      end
      if (sr_ff > ACC_W'(signed'({1'b0, {(FACE_W-1){1'b1}}}))) begin
         face = {1'b0, {(FACE_W-1){1'b1}}};
      end else if (sr_ff < ACC_W'(signed'({1'b1, {(FACE_W-1){1'b0}}}))) begin
         face = {1'b1, {(FACE_W-1){1'b0}}};
      end else begin
         face = FACE_W'(sr_ff);
      end
   end

   // saturating running sum for the selected plane
   always_comb begin
      sum_ext = (job_ff.temporal ? (TOTAL_W+1)'(temporal_ff) : (TOTAL_W+1)'(spatial_ff))
                + (TOTAL_W+1)'(face);
      sum_ovf = sum_ext[TOTAL_W] ^ sum_ext[TOTAL_W-1];
      if (sum_ovf) begin
         sum_sat = sum_ext[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                    : {1'b0, {(TOTAL_W-1){1'b1}}};
      end else begin
         sum_sat = sum_ext[TOTAL_W-1:0];
      end
   end

   assign slot_free = ~rsp_valid_ff | rsp.ready;
   assign idle      = (state_ff == S_IDLE);
   assign pop       = idle & ~queue_empty;

   // sequencer, accumulators and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= P_AB;
         row_ff       <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
         pv_ff        <= 1'b0;
         spatial_ff   <= '0;
         temporal_ff  <= '0;
         count_ff     <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pv_ff   <= (state_ff == S_M0) || (state_ff == S_M1)
                    || (state_ff == S_M2) || (state_ff == S_M3);
         prod_ff <= prod_in;
         case (state_ff)
            S_M0:    psel_ff <= 2'd0;
            S_M1:    psel_ff <= 2'd1;
            S_M2:    psel_ff <= 2'd2;
            default: psel_ff <= 2'd3;
         endcase

         // accumulate the product issued in the previous cycle
         if (pv_ff) begin
            case (psel_ff)
               2'd0: sr_ff <= sr_ff + rnd;
               2'd1: sr_ff <= (phase_ff == P_AB) ? sr_ff - rnd : sr_ff + rnd;
               2'd2: if (phase_ff != P_FACE) si_ff <= si_ff + rnd;
               default: begin
                  if (phase_ff == P_AB) begin
                     si_ff <= si_ff + rnd;
                  end else if (phase_ff == P_TC) begin
                     si_ff <= si_ff - rnd;
                  end
               end
            endcase
         end

         // result register handshake
         if (state_ff == S_OUT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (!queue_empty) begin
                  job_ff   <= head;
                  phase_ff <= P_AB;
                  row_ff   <= '0;
                  col_ff   <= '0;
                  k_ff     <= '0;
                  sr_ff    <= '0;
                  si_ff    <= '0;
                  state_ff <= S_RDX;
               end
            end
            S_RDX: state_ff <= S_RDY;
            S_RDY: begin
               case (phase_ff)
                  P_AB:    {x_re_ff, x_im_ff} <= rd_data;
                  P_TC:    {x_re_ff, x_im_ff} <= t_ff[ik];
                  default: {x_re_ff, x_im_ff} <= u_ff[rc];
               endcase
               state_ff <= S_LATY;
            end
            S_LATY: begin
               {y_re_ff, y_im_ff} <= rd_data;
               state_ff <= S_M0;
            end
            S_M0: state_ff <= S_M1;
            S_M1: state_ff <= S_M2;
            S_M2: state_ff <= S_M3;
            S_M3: state_ff <= S_NEXT;
            S_NEXT: begin
               if (phase_ff != P_FACE && k_ff != CW'(COLORS - 1)) begin
                  k_ff     <= k_ff + CW'(1);
                  state_ff <= S_RDX;
               end else begin
                  state_ff <= S_STORE;
               end
            end
            S_STORE: begin
               // write the finished A*B or T*C entry, step to the next one
               if (phase_ff == P_AB) begin
                  t_ff[rc] <= {sr_clamp[ELEM_W-1:0], si_clamp[ELEM_W-1:0]};
               end else if (phase_ff == P_TC) begin
                  u_ff[rc] <= {sr_clamp[ELEM_W-1:0], si_clamp[ELEM_W-1:0]};
               end
               if (phase_ff != P_FACE) begin
                  sr_ff <= '0;
                  si_ff <= '0;
               end
               k_ff <= '0;
               // the last face entry hands over to the result stage
               if (phase_ff == P_FACE && row_ff == CW'(COLORS - 1)
                   && col_ff == CW'(COLORS - 1)) begin
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_RDX;
               end
               if (col_ff != CW'(COLORS - 1)) begin
                  col_ff <= col_ff + CW'(1);
               end else begin
                  col_ff <= '0;
                  if (row_ff != CW'(COLORS - 1)) begin
                     row_ff <= row_ff + CW'(1);
                  end else begin
                     row_ff <= '0;
                     case (phase_ff)
                        P_AB:    phase_ff <= P_TC;
                        P_TC:    phase_ff <= P_FACE;
                        default: phase_ff <= P_FACE;
                     endcase
                  end
               end
            end
            S_OUT: begin
               if (slot_free) begin
                  rsp_face_ff    <= face;
                  rsp_done_ff    <= job_ff.last;
                  rsp_ovf_ff     <= sat_ff | sum_ovf;
                  rsp_count_ff   <= (&count_ff) ? count_ff : count_ff + COUNT_W'(1);
                  rsp_spatial_ff  <= job_ff.temporal ? spatial_ff : sum_sat;
                  rsp_temporal_ff <= job_ff.temporal ? sum_sat : temporal_ff;
                  if (job_ff.last) begin
                     spatial_ff  <= '0;
                     temporal_ff <= '0;
                     count_ff    <= '0;
                     sat_ff      <= 1'b0;
                  end else begin
                     if (job_ff.temporal) begin
                        temporal_ff <= sum_sat;
                     end else begin
                        spatial_ff <= sum_sat;
                     end
                     count_ff <= (&count_ff) ? count_ff : count_ff + COUNT_W'(1);
                     sat_ff   <= sat_ff | sum_ovf;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.face_value     = rsp_face_ff;
   assign rsp.spatial_total  = rsp_spatial_ff;
   assign rsp.temporal_total = rsp_temporal_ff;
   assign rsp.faces_seen     = rsp_count_ff;
   assign rsp.sweep_done     = rsp_done_ff;
   assign rsp.overflowed     = rsp_ovf_ff;
endmodule

### hdl/su3_plaquette_accumulator_core.sv
// channel  | direction | contents
// req_ch   | in        | one link element: slot, index, re, im, plane, batch end
// rsp_ch   | out       | face value, spatial and temporal sums, count, flags
//
// an element that is not the last of D is stored; the last one also starts a face job
// that runs up to the result: each product term takes two reads through the registered
// link store port and four issues on the single shared 32x32 multiplier, and each entry
// ends with a store step
// req_ch is held off while a face job is queued or running, or waits for the result slot
// reset is synchronous and clears sums, count, overflow flag and control; link store
// contents stay undefined until written
module su3_plaquette_accumulator_core #(
   parameter int COLORS    = spa_pkg::DEF_COLORS,
   parameter int FRAC_BITS = spa_pkg::DEF_FRAC_BITS
) (
   input logic       clock,
   input logic       reset,
   spa_req_if.sink   req_ch,
   spa_rsp_if.source rsp_ch
);
   import spa_pkg::*;

   localparam int DEPTH = SLOTS * COLORS * COLORS;
   localparam int AW    = $clog2(DEPTH);

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [2*ELEM_W-1:0] wr_data;
   logic [AW-1:0]       rd_addr;
   logic [2*ELEM_W-1:0] rd_data;
   logic                push, pop, queue_empty, back_idle;
   job_type             push_job, head;

   // front: element intake and job detection
   spa_front #(.COLORS(COLORS)) u_front (
      .req(req_ch), .back_idle(back_idle), .queue_empty(queue_empty),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .push(push), .job(push_job)
   );

   // link store
   spa_ram #(.WIDTH(2 * ELEM_W), .DEPTH(DEPTH)) u_links (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // job queue between front and back
   spa_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_job(push_job),
      .pop(pop), .empty(queue_empty), .head(head)
   );

   // back: matrix products, face value and sums
   spa_back #(.COLORS(COLORS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .queue_empty(queue_empty), .head(head),
      .pop(pop), .idle(back_idle), .rd_addr(rd_addr), .rd_data(rd_data),
      .rsp(rsp_ch)
   );
endmodule
